// ===== rtl/core/sov_pkg.sv =====
// Shared widths, register indexes and stage data types for the sphere overlap test.
`timescale 1ns / 1ps

package sov_pkg;

   localparam int XW         = 96;   // squared length, scaled for the square root
   localparam int REMW       = 50;   // square root partial remainder
   localparam int ROOTW      = 48;   // length with 15 fractional bits
   localparam int MAGW       = 33;   // magnitude of one difference component
   localparam int SQW        = 66;   // sum of the three squares
   localparam int QW         = 18;   // normal quotient bits
   localparam int DREMW      = 48;   // divider partial remainder
   localparam int SQRT_CELLS = 48;
   localparam int DIV_CELLS  = 18;
   localparam int LATENCY    = 73;

   localparam logic [1:0] CSR_CENTER_X   = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y   = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z   = 2'd2;
   localparam logic [1:0] CSR_OWN_RADIUS = 2'd3;

   localparam logic [30:0] RADIUS_RESET = 31'd65536;
   localparam logic [16:0] NORMAL_ONE   = 17'd65536;
   localparam logic [31:0] POS_LIMIT    = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;

   typedef struct packed {
      logic [XW-1:0]             x;
      logic [REMW-1:0]           rem;
      logic [ROOTW-1:0]          root;
      logic [2:0][MAGW-1:0]      mag;
      logic [2:0]                neg;
      logic                      touch;
   } sqrt_data_type;

   typedef struct packed {
      logic [2:0][DREMW-1:0]     rem;
      logic [2:0][QW-1:0]        low;
      logic [2:0][QW-1:0]        quo;
      logic [ROOTW-1:0]          len;
      logic [2:0]                neg;
      logic                      touch;
      logic                      zero;
   } div_data_type;

endpackage

// ===== rtl/core/sov_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the length per cycle.
`timescale 1ns / 1ps

module sov_sqrt_cell
   import sov_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  sqrt_data_type in_data,
   output logic          out_valid,
   output sqrt_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   sqrt_data_type data_ff;
   sqrt_data_type data_in;
   logic [REMW+1:0] rem_sh;
   logic [REMW+1:0] trial;

   always_comb begin
      valid_in = in_valid;
      data_in  = in_data;
      rem_sh   = {in_data.rem, in_data.x[XW-1 -: 2]};
      trial    = {2'b00, in_data.root, 2'b01};
      data_in.x = {in_data.x[XW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = REMW'(rem_sh - trial);
         data_in.root = {in_data.root[ROOTW-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh[REMW-1:0];
         data_in.root = {in_data.root[ROOTW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/sov_div_cell.sv =====
// One cell of the normal divider chain: one quotient bit per axis per cycle.
`timescale 1ns / 1ps

module sov_div_cell
   import sov_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  div_data_type in_data,
   output logic         out_valid,
   output div_data_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   div_data_type data_ff;
   div_data_type data_in;
   logic [DREMW:0] rem_sh [3];
   logic [DREMW:0] divisor;

   always_comb begin
      valid_in = in_valid;
      data_in  = in_data;
      divisor  = {1'b0, in_data.len};
      for (int l = 0; l < 3; l++) begin
         rem_sh[l] = {in_data.rem[l], in_data.low[l][QW-1]};
         data_in.low[l] = {in_data.low[l][QW-2:0], 1'b0};
         if (rem_sh[l] >= divisor) begin
            data_in.rem[l] = DREMW'(rem_sh[l] - divisor);
            data_in.quo[l] = {in_data.quo[l][QW-2:0], 1'b1};
         end else begin
            data_in.rem[l] = rem_sh[l][DREMW-1:0];
            data_in.quo[l] = {in_data.quo[l][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/sphere_overlap_test_unit.sv =====
// Top level of the sphere overlap test: front end, cell chains and result stages.
`timescale 1ns / 1ps

// The block holds one sphere in four registers written through the csr_ channel
// (index 0..2 center x/y/z, index 3 radius); a write completes when csr_valid and
// csr_ready are both high. Write them only while no item is in flight.
// An item is accepted at a clock edge where start is high and busy is low. busy is
// high only during reset, so one item can be accepted in every cycle.
// Each item produces exactly one result, shown for one cycle with rsp_valid high
// once it leaves stage F3. Its path runs through stages A to C, the 48-cell
// square root chain (one length bit per cell), stage P, the 18-cell divider chain
// (one normal bit per cell) and stages F1 to F3: seven front and back stages.
// Throughput is one item per cycle.
// The receiver cannot stall; results are presented once and must be taken.
// Reset is synchronous: it empties every stage, so items in flight are dropped,
// and it returns the center to zero and the radius to 1.0.

module sphere_overlap_test_unit
   import sov_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   input  logic signed [31:0] req_query_z,
   input  logic [30:0]        req_query_radius,
   output logic               rsp_valid,
   output logic               rsp_touching,
   output logic signed [17:0] rsp_normal_x,
   output logic signed [17:0] rsp_normal_y,
   output logic signed [17:0] rsp_normal_z,
   output logic signed [31:0] rsp_contact_x,
   output logic signed [31:0] rsp_contact_y,
   output logic signed [31:0] rsp_contact_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // Configuration registers.
   logic [31:0] center_ff [3];
   logic [30:0] radius_ff;

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= RADIUS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_ff[0] <= csr_wdata;
            CSR_CENTER_Y:   center_ff[1] <= csr_wdata;
            CSR_CENTER_Z:   center_ff[2] <= csr_wdata;
            CSR_OWN_RADIUS: radius_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Stage A: difference vector magnitudes and radius sum.
   logic [31:0]     query [3];
   logic [MAGW-1:0] diff_a [3];
   logic            valid_a_ff;
   logic [MAGW-1:0] mag_a_ff [3];
   logic [2:0]      neg_a_ff;
   logic [31:0]     rsum_a_ff;

   assign query[0] = req_query_x;
   assign query[1] = req_query_y;
   assign query[2] = req_query_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_a[i] = {center_ff[i][31], center_ff[i]} - {query[i][31], query[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
      for (int i = 0; i < 3; i++) begin
         mag_a_ff[i] <= diff_a[i][MAGW-1] ? MAGW'(-diff_a[i]) : diff_a[i];
         neg_a_ff[i] <= diff_a[i][MAGW-1];
      end
      rsum_a_ff <= {1'b0, req_query_radius} + {1'b0, radius_ff};
   end

   // Stage B: squares.
   logic            valid_b_ff;
   logic [SQW-1:0]  sq_b_ff [3];
   logic [63:0]     rs2_b_ff;
   logic [MAGW-1:0] mag_b_ff [3];
   logic [2:0]      neg_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      for (int i = 0; i < 3; i++) begin
         sq_b_ff[i]  <= SQW'(mag_a_ff[i]) * SQW'(mag_a_ff[i]);
         mag_b_ff[i] <= mag_a_ff[i];
      end
      neg_b_ff <= neg_a_ff;
      rs2_b_ff <= 64'(rsum_a_ff) * 64'(rsum_a_ff);
   end

   // Stage C: squared length.
   logic            valid_c_ff;
   logic [SQW-1:0]  sum_c_ff;
   logic [63:0]     rs2_c_ff;
   logic [MAGW-1:0] mag_c_ff [3];
   logic [2:0]      neg_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      sum_c_ff <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      rs2_c_ff <= rs2_b_ff;
      mag_c_ff <= mag_b_ff;
      neg_c_ff <= neg_b_ff;
   end

   // Square root chain.
   logic [SQRT_CELLS:0] sqrt_valid;
   sqrt_data_type       sqrt_link [SQRT_CELLS+1];

   always_comb begin
      sqrt_valid[0]      = valid_c_ff;
      sqrt_link[0].x     = {sum_c_ff, 30'b0};
      sqrt_link[0].rem   = '0;
      sqrt_link[0].root  = '0;
      for (int i = 0; i < 3; i++) begin
         sqrt_link[0].mag[i] = mag_c_ff[i];
      end
      sqrt_link[0].neg   = neg_c_ff;
      sqrt_link[0].touch = sum_c_ff < {2'b00, rs2_c_ff};
   end

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      sov_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_valid[g]),
         .in_data   (sqrt_link[g]),
         .out_valid (sqrt_valid[g+1]),
         .out_data  (sqrt_link[g+1])
      );
   end

   // Stage P: rounded dividends for the normal.
   logic           valid_p_ff;
   div_data_type   div_p_ff;
   logic [63:0]    num_p [3];
   sqrt_data_type  sq_end;

   assign sq_end = sqrt_link[SQRT_CELLS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_p[i] = {sq_end.mag[i], 31'b0} + 64'(sq_end.root[ROOTW-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
      end else begin
         valid_p_ff <= sqrt_valid[SQRT_CELLS];
      end
      for (int i = 0; i < 3; i++) begin
         div_p_ff.rem[i] <= {2'b00, num_p[i][63:QW]};
         div_p_ff.low[i] <= num_p[i][QW-1:0];
         div_p_ff.quo[i] <= '0;
      end
      div_p_ff.len   <= sq_end.root;
      div_p_ff.neg   <= sq_end.neg;
      div_p_ff.touch <= sq_end.touch;
      div_p_ff.zero  <= (sq_end.root == '0);
   end

   // Divider chain.
   logic [DIV_CELLS:0] div_valid;
   div_data_type       div_link [DIV_CELLS+1];

   assign div_valid[0] = valid_p_ff;
   assign div_link[0]  = div_p_ff;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      sov_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_data   (div_link[g]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_link[g+1])
      );
   end

   // Stage F1: clamped normal magnitude, zero for a zero length.
   div_data_type div_end;
   logic         valid_f1_ff;
   logic [16:0]  nm_f1_ff [3];
   logic [2:0]   neg_f1_ff;
   logic         touch_f1_ff;

   assign div_end = div_link[DIV_CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f1_ff <= 1'b0;
      end else begin
         valid_f1_ff <= div_valid[DIV_CELLS];
      end
      for (int i = 0; i < 3; i++) begin
         if (div_end.zero) begin
            nm_f1_ff[i] <= '0;
         end else if (div_end.quo[i] > QW'(NORMAL_ONE)) begin
            nm_f1_ff[i] <= NORMAL_ONE;
         end else begin
            nm_f1_ff[i] <= div_end.quo[i][16:0];
         end
      end
      neg_f1_ff   <= div_end.neg;
      touch_f1_ff <= div_end.touch;
   end

   // Stage F2: contact magnitude, rounded.
   logic        valid_f2_ff;
   logic [31:0] cm_f2_ff [3];
   logic [16:0] nm_f2_ff [3];
   logic [2:0]  neg_f2_ff;
   logic        touch_f2_ff;
   logic [47:0] prod_f2 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_f2[i] = 48'(nm_f1_ff[i]) * 48'(radius_ff) + 48'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f2_ff <= 1'b0;
      end else begin
         valid_f2_ff <= valid_f1_ff;
      end
      for (int i = 0; i < 3; i++) begin
         cm_f2_ff[i] <= prod_f2[i][47:16];
      end
      nm_f2_ff    <= nm_f1_ff;
      neg_f2_ff   <= neg_f1_ff;
      touch_f2_ff <= touch_f1_ff;
   end

   // Stage F3: signs and saturation into the result registers.
   logic        valid_f3_ff;
   logic        touch_f3_ff;
   logic [17:0] normal_f3_ff [3];
   logic [31:0] contact_f3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f3_ff <= 1'b0;
      end else begin
         valid_f3_ff <= valid_f2_ff;
      end
      touch_f3_ff <= touch_f2_ff;
      for (int i = 0; i < 3; i++) begin
         if (neg_f2_ff[i]) begin
            normal_f3_ff[i]  <= 18'(-{1'b0, nm_f2_ff[i]});
            contact_f3_ff[i] <= (cm_f2_ff[i] > NEG_LIMIT) ? NEG_LIMIT : 32'(-cm_f2_ff[i]);
         end else begin
            normal_f3_ff[i]  <= {1'b0, nm_f2_ff[i]};
            contact_f3_ff[i] <= (cm_f2_ff[i] > POS_LIMIT) ? POS_LIMIT : cm_f2_ff[i];
         end
      end
   end

   assign rsp_valid     = valid_f3_ff;
   assign rsp_touching  = touch_f3_ff;
   assign rsp_normal_x  = normal_f3_ff[0];
   assign rsp_normal_y  = normal_f3_ff[1];
   assign rsp_normal_z  = normal_f3_ff[2];
   assign rsp_contact_x = contact_f3_ff[0];
   assign rsp_contact_y = contact_f3_ff[1];
   assign rsp_contact_z = contact_f3_ff[2];

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_normal_x) <= 65536 && $signed(rsp_normal_x) >= -65536
                     && $signed(rsp_normal_y) <= 65536 && $signed(rsp_normal_y) >= -65536
                     && $signed(rsp_normal_z) <= 65536 && $signed(rsp_normal_z) >= -65536))
      else $error("normal component out of unit range");

   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      |-> (rsp_contact_x == 0 && rsp_contact_y == 0 && rsp_contact_z == 0))
      else $error("contact nonzero for a zero normal");

   a_contact_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_normal_x[17]) |-> (rsp_contact_x[31] || rsp_contact_x == 0))
      else $error("contact sign differs from normal sign");
`endif

endmodule
